[rtl/bfc_pkg.sv]
// Shared constants, codes and types of the banked flash command controller.
`default_nettype none

package bfc_pkg;

	localparam int MAIN_BYTES            = 2097152;
	localparam int BACKUP_BYTES          = 262144;
	localparam int PASSTHROUGH_MAX_BYTES = 1048576;
	localparam int UNIT_BYTES            = 65536;

	localparam int POS_W  = 21;
	localparam int LEN_W  = 17;
	localparam int SIZE_W = 22;

	localparam logic [4:0] PT_MAX_UNITS = 5'(PASSTHROUGH_MAX_BYTES / UNIT_BYTES);

	// bus actions
	localparam logic [2:0] ACT_FLASH_RD = 3'd0;
	localparam logic [2:0] ACT_FLASH_WR = 3'd1;
	localparam logic [2:0] ACT_IO_RD    = 3'd2;
	localparam logic [2:0] ACT_IO_WR    = 3'd3;
	localparam logic [2:0] ACT_WARM_RST = 3'd4;

	// memory commands
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_READ  = 3'd1;
	localparam logic [2:0] OP_PROG  = 3'd2;
	localparam logic [2:0] OP_ESECT = 3'd3;
	localparam logic [2:0] OP_ECHIP = 3'd4;
	localparam logic [2:0] OP_IMM   = 3'd5;

	localparam logic [1:0] CHIP_MAIN   = 2'd0;
	localparam logic [1:0] CHIP_BACKUP = 2'd1;
	localparam logic [1:0] CHIP_PASS   = 2'd2;

	// I/O register numbers
	localparam logic [3:0] REG_ID      = 4'd0;
	localparam logic [3:0] REG_CONTROL = 4'd1;
	localparam logic [3:0] REG_STATUS  = 4'd2;
	localparam logic [3:0] REG_REV     = 4'd9;

	// configuration register indexes
	localparam logic CFG_BANK_SWITCHES = 1'b0;
	localparam logic CFG_PT_SIZE       = 1'b1;

	// flash command bytes and unlock addresses
	localparam logic [7:0] FC_RESET    = 8'hF0;
	localparam logic [7:0] FC_UNLOCK1  = 8'hAA;
	localparam logic [7:0] FC_UNLOCK2  = 8'h55;
	localparam logic [7:0] FC_ERASE    = 8'h80;
	localparam logic [7:0] FC_AUTOSEL  = 8'h90;
	localparam logic [7:0] FC_PROGRAM  = 8'hA0;
	localparam logic [7:0] FC_CHIP_ER  = 8'h10;
	localparam logic [7:0] FC_SECT_ER  = 8'h30;

	localparam logic [15:0] ADDR_5555 = 16'h5555;
	localparam logic [15:0] ADDR_0555 = 16'h0555;
	localparam logic [15:0] ADDR_2AAA = 16'h2AAA;
	localparam logic [15:0] ADDR_02AA = 16'h02AA;

	localparam logic [7:0] ID_MAIN_MFR   = 8'h01;
	localparam logic [7:0] ID_MAIN_DEV   = 8'hAD;
	localparam logic [7:0] ID_BACKUP_MFR = 8'h1C;
	localparam logic [7:0] ID_BACKUP_DEV = 8'h92;
	localparam logic [7:0] REG_ID_VAL    = 8'hE1;
	localparam logic [7:0] REG_REV_VAL   = 8'h69;

	localparam logic [7:0] CONTROL_RST = 8'h0F;
	localparam logic [3:0] SWITCH_RST  = 4'hF;

	typedef enum logic [2:0] {
		CMD_IDLE,
		CMD_UNLOCK1,
		CMD_UNLOCK2,
		CMD_ERASE1,
		CMD_ERASE2,
		CMD_ERASE3,
		CMD_AUTOSEL,
		CMD_PROGRAM
	} cmd_state_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_DIV,
		SEQ_EXEC
	} seq_state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic exec;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_status_t;

endpackage

`default_nettype wire

[rtl/bfc_rem.sv]
// Iterative remainder unit: 8-bit dividend modulo a 5-bit divisor, one bit a cycle.
`default_nettype none

module bfc_rem
	import bfc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [7:0] dividend,
	input  wire logic [4:0] divisor,
	output logic            done,
	output logic [3:0]      rem
);

	logic [7:0] shift_q;
	logic [4:0] rem_q;
	logic [4:0] div_q;
	logic [2:0] cnt_q;
	logic       busy_q;
	logic       done_q;
	logic [4:0] trial;

	// remainder stays below the divisor (at most 16), so four bits carry over
	assign trial = {rem_q[3:0], shift_q[7]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
			div_q   <= divisor;
		end else if (busy_q) begin
			shift_q <= {shift_q[6:0], 1'b0};
			if (trial >= div_q) begin
				rem_q <= trial - div_q;
			end else begin
				rem_q <= trial;
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q[3:0];

endmodule

`default_nettype wire

[rtl/bfc_ctrl.sv]
// Sequencer: request intake, remainder wait, execute and output handshake.
`default_nettype none

module bfc_ctrl
	import bfc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	seq_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_stall      = 1'b1;
		unique case (state_q)
			SEQ_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (status.need_div) begin
						cmd.div_start = 1'b1;
						state_d       = SEQ_DIV;
					end else begin
						state_d = SEQ_EXEC;
					end
				end
			end
			SEQ_DIV: begin
				if (status.div_done) begin
					state_d = SEQ_EXEC;
				end
			end
			SEQ_EXEC: begin
				// result register must be free or draining this cycle
				if (!out_valid_q || !out_stall) begin
					cmd.exec = 1'b1;
					state_d  = SEQ_IDLE;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/bfc_datapath.sv]
// Datapath: config, control/status and command state, window mapping, result register.
`default_nettype none

module bfc_datapath
	import bfc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_cmd_t         cmd,
	output dp_status_t             status,
	input  wire logic              wr_en,
	input  wire logic              wr_index,
	input  wire logic [4:0]        wr_data,
	input  wire logic [2:0]        action,
	input  wire logic [23:0]       offset,
	input  wire logic [3:0]        reg_index,
	input  wire logic [31:0]       write_data,
	input  wire logic [2:0]        access_size,
	output logic [2:0]             mem_op,
	output logic [1:0]             chip_select,
	output logic [POS_W-1:0]       mem_pos,
	output logic [LEN_W-1:0]       erase_length,
	output logic [31:0]            read_data
);

	localparam logic [POS_W-1:0]  MAIN_MASK = POS_W'(MAIN_BYTES - 1);
	localparam logic [SIZE_W-1:0] MAIN_SIZE = SIZE_W'(MAIN_BYTES);
	localparam logic [SIZE_W-1:0] BACK_SIZE = SIZE_W'(BACKUP_BYTES);

	function automatic logic [31:0] size_mask(input logic [2:0] sz);
		logic [31:0] m;
		case (sz)
			3'd0, 3'd1: m = 32'h0000_00FF;
			3'd2:       m = 32'h0000_FFFF;
			3'd3:       m = 32'h00FF_FFFF;
			default:    m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	// configuration and architectural state
	logic [3:0]  bank_sw_q;
	logic [4:0]  pt_units_q;
	logic [7:0]  control_q;
	logic [7:0]  status_q;
	cmd_state_t  cmd_state_q;

	// captured request
	logic [2:0]  action_q;
	logic [23:0] offset_q;
	logic [3:0]  reg_q;
	logic [31:0] wdata_q;
	logic [2:0]  size_q;

	// result register
	logic [2:0]        op_q;
	logic [1:0]        chip_q;
	logic [POS_W-1:0]  pos_q;
	logic [LEN_W-1:0]  len_q;
	logic [31:0]       rdata_q;

	logic [4:0] units_sat;
	logic       in_pass, in_backup, mapped;
	logic [3:0] bank;
	logic [3:0] pt_rem;
	logic       rem_done;

	logic [POS_W-1:0] main_pos, back_pos, pass_pos, res_pos, sect_base;
	logic [1:0]       res_chip;
	logic [LEN_W-1:0] sect_len, sect_len_raw;
	logic [SIZE_W-1:0] sect_end, chip_bytes;

	logic [7:0]  wbyte;
	logic [15:0] cmd_addr;
	logic        a5, a2;

	logic [2:0]        op_d;
	logic [1:0]        chip_d;
	logic [POS_W-1:0]  pos_d;
	logic [LEN_W-1:0]  len_d;
	logic [31:0]       rdata_d;
	cmd_state_t        cmd_state_d;
	logic [7:0]        control_d, status_d;

	assign units_sat = (pt_units_q > PT_MAX_UNITS) ? PT_MAX_UNITS : pt_units_q;
	assign in_pass   = control_q[5];
	assign in_backup = control_q[7];
	assign mapped    = !in_pass || (units_sat != 5'd0);
	assign bank      = status_q[7] ? status_q[3:0] : bank_sw_q;

	// only mapped passthrough reads need the window folded by the size
	assign status.need_div = (action == ACT_FLASH_RD) && (cmd_state_q != CMD_AUTOSEL) &&
		in_pass && (units_sat != 5'd0);
	assign status.div_done = rem_done;

	bfc_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (offset[23:16]),
		.divisor  (units_sat),
		.done     (rem_done),
		.rem      (pt_rem)
	);

	always_comb begin
		if (bank < 4'd8) begin
			main_pos = {bank[2:0], offset_q[17:0]};
		end else if (bank < 4'd12) begin
			main_pos = {bank[1:0], offset_q[18:0]};
		end else if (bank < 4'd14) begin
			main_pos = {bank[0], offset_q[19:0]};
		end else begin
			main_pos = offset_q[20:0];
		end
		main_pos = main_pos & MAIN_MASK;
	end

	assign back_pos = {3'b000, offset_q[17:0]};
	assign pass_pos = {1'b0, pt_rem, offset_q[15:0]};
	assign res_pos  = in_pass ? pass_pos : (in_backup ? back_pos : main_pos);
	assign res_chip = in_pass ? CHIP_PASS : (in_backup ? CHIP_BACKUP : CHIP_MAIN);

	// sector geometry (backup flash has a small boot-block tail)
	always_comb begin
		if (!in_backup || res_pos <= POS_W'(24'h2FFFF)) begin
			sect_len_raw = LEN_W'(65536);
		end else if (res_pos <= POS_W'(24'h37FFF)) begin
			sect_len_raw = LEN_W'(32768);
		end else if (res_pos <= POS_W'(24'h3BFFF)) begin
			sect_len_raw = LEN_W'(8192);
		end else begin
			sect_len_raw = LEN_W'(16384);
		end
		sect_base  = res_pos & ~(POS_W'(sect_len_raw) - POS_W'(1));
		chip_bytes = in_backup ? BACK_SIZE : MAIN_SIZE;
		sect_end   = SIZE_W'(sect_base) + SIZE_W'(sect_len_raw);
		if (sect_end > chip_bytes) begin
			sect_len = LEN_W'(chip_bytes - SIZE_W'(sect_base));
		end else begin
			sect_len = sect_len_raw;
		end
	end

	assign wbyte    = wdata_q[7:0];
	assign cmd_addr = offset_q[15:0];
	assign a5       = (cmd_addr == ADDR_5555) || (cmd_addr == ADDR_0555);
	assign a2       = (cmd_addr == ADDR_2AAA) || (cmd_addr == ADDR_02AA);

	always_comb begin
		op_d        = OP_NONE;
		chip_d      = CHIP_MAIN;
		pos_d       = '0;
		len_d       = '0;
		rdata_d     = '0;
		cmd_state_d = cmd_state_q;
		control_d   = control_q;
		status_d    = status_q;
		case (action_q)
			ACT_FLASH_RD: begin
				if (cmd_state_q == CMD_AUTOSEL) begin
					op_d = OP_IMM;
					if (offset_q[1:0] == 2'd0) begin
						rdata_d = {24'd0, in_backup ? ID_BACKUP_MFR : ID_MAIN_MFR};
					end else if (offset_q[1:0] == 2'd1) begin
						rdata_d = {24'd0, in_backup ? ID_BACKUP_DEV : ID_MAIN_DEV};
					end
				end else if (mapped) begin
					op_d   = OP_READ;
					chip_d = res_chip;
					pos_d  = res_pos;
				end else begin
					op_d    = OP_IMM;
					rdata_d = size_mask(size_q);
				end
			end
			ACT_FLASH_WR: begin
				if (cmd_state_q != CMD_PROGRAM && wbyte == FC_RESET) begin
					cmd_state_d = CMD_IDLE;
				end else begin
					unique case (cmd_state_q)
						CMD_IDLE: begin
							if (a5 && wbyte == FC_UNLOCK1) cmd_state_d = CMD_UNLOCK1;
						end
						CMD_UNLOCK1: begin
							cmd_state_d = (a2 && wbyte == FC_UNLOCK2) ? CMD_UNLOCK2 : CMD_IDLE;
						end
						CMD_UNLOCK2: begin
							if (a5 && wbyte == FC_ERASE) cmd_state_d = CMD_ERASE1;
							else if (a5 && wbyte == FC_AUTOSEL) cmd_state_d = CMD_AUTOSEL;
							else if (a5 && wbyte == FC_PROGRAM) cmd_state_d = CMD_PROGRAM;
							else cmd_state_d = CMD_IDLE;
						end
						CMD_ERASE1: begin
							cmd_state_d = (a5 && wbyte == FC_UNLOCK1) ? CMD_ERASE2 : CMD_IDLE;
						end
						CMD_ERASE2: begin
							cmd_state_d = (a2 && wbyte == FC_UNLOCK2) ? CMD_ERASE3 : CMD_IDLE;
						end
						CMD_ERASE3: begin
							if (a5 && wbyte == FC_CHIP_ER) begin
								if (!in_pass) begin
									op_d   = OP_ECHIP;
									chip_d = in_backup ? CHIP_BACKUP : CHIP_MAIN;
								end
							end else if (wbyte == FC_SECT_ER && !in_pass) begin
								op_d   = OP_ESECT;
								chip_d = res_chip;
								pos_d  = sect_base;
								len_d  = sect_len;
							end
							cmd_state_d = CMD_IDLE;
						end
						CMD_PROGRAM: begin
							if (!in_pass) begin
								op_d    = OP_PROG;
								chip_d  = res_chip;
								pos_d   = res_pos;
								rdata_d = wdata_q & size_mask(size_q);
							end
							cmd_state_d = CMD_IDLE;
						end
						CMD_AUTOSEL: ; // held until a reset command
						default: cmd_state_d = CMD_IDLE;
					endcase
				end
			end
			ACT_IO_RD: begin
				op_d = OP_IMM;
				unique case (reg_q)
					REG_ID:      rdata_d = {24'd0, REG_ID_VAL};
					REG_REV:     rdata_d = {24'd0, REG_REV_VAL};
					REG_CONTROL: rdata_d = status_q[7] ? {24'd0, control_q} : {28'd0, bank_sw_q};
					REG_STATUS:  rdata_d = {24'd0, status_q};
					default:     rdata_d = '0;
				endcase
			end
			ACT_IO_WR: begin
				if (reg_q == REG_CONTROL) control_d = wdata_q[7:0];
				else if (reg_q == REG_STATUS) status_d = wdata_q[7:0];
			end
			ACT_WARM_RST: cmd_state_d = CMD_IDLE;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_sw_q   <= SWITCH_RST;
			pt_units_q  <= '0;
			control_q   <= CONTROL_RST;
			status_q    <= '0;
			cmd_state_q <= CMD_IDLE;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					CFG_BANK_SWITCHES: bank_sw_q  <= wr_data[3:0];
					CFG_PT_SIZE:       pt_units_q <= wr_data;
					default: ;
				endcase
			end
			if (cmd.exec) begin
				control_q   <= control_d;
				status_q    <= status_d;
				cmd_state_q <= cmd_state_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			offset_q <= offset;
			reg_q    <= reg_index;
			wdata_q  <= write_data;
			size_q   <= access_size;
		end
		if (cmd.exec) begin
			op_q    <= op_d;
			chip_q  <= chip_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			rdata_q <= rdata_d;
		end
	end

	assign mem_op       = op_q;
	assign chip_select  = chip_q;
	assign mem_pos      = pos_q;
	assign erase_length = len_q;
	assign read_data    = rdata_q;

endmodule

`default_nettype wire

[rtl/banked_flash_command_controller.sv]
// Banked flash command controller: sequencer and datapath.
// One bus access goes in on the request channel (in_valid / in_stall) and exactly
// one memory command comes out on the result channel (out_valid / out_stall).
// A request is taken at a clock edge with valid high and stall low.
// Most accesses are first captured, then decoded: the decode updates the command
// state and loads the result register, and out_valid rises on the cycle after
// that. A flash read while the passthrough flash is mapped also waits for
// the bit-serial remainder unit that folds the window onto the configured
// passthrough size.
// The result register decouples the sides: a new request is captured while a
// result waits; a stalled result holds until taken and the next decode waits
// for the register to free up.
// Configuration: wr_en / wr_index / wr_data, no read-back;
// write only while no request is in flight.
// Reset (arst_n low): command state idle, control 0x0F, status 0, bank switches
// 0xF, passthrough size 0, no result pending.
`default_nettype none

module banked_flash_command_controller
	import bfc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic              wr_index,
	input  wire logic [4:0]        wr_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        action,
	input  wire logic [23:0]       offset,
	input  wire logic [3:0]        reg_index,
	input  wire logic [31:0]       write_data,
	input  wire logic [2:0]        access_size,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [2:0]             mem_op,
	output logic [1:0]             chip_select,
	output logic [POS_W-1:0]       mem_pos,
	output logic [LEN_W-1:0]       erase_length,
	output logic [31:0]            read_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	bfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	bfc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.action       (action),
		.offset       (offset),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.access_size  (access_size),
		.mem_op       (mem_op),
		.chip_select  (chip_select),
		.mem_pos      (mem_pos),
		.erase_length (erase_length),
		.read_data    (read_data)
	);

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for banked_flash_command_controller: random JEDEC traffic vs a predictor.
module testbench;
	import bfc_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_REQS   = 305;
	localparam logic [2:0] ACT_UNUSED = 3'd7;

	typedef struct packed {
		logic [2:0]  act;
		logic [23:0] off;
		logic [3:0]  reg_no;
		logic [31:0] wdata;
		logic [2:0]  nbytes;
	} bus_req_t;

	typedef struct packed {
		logic [2:0]       op;
		logic [1:0]       chip;
		logic [POS_W-1:0] pos;
		logic [LEN_W-1:0] len;
		logic [31:0]      data;
	} mem_cmd_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              wr_en       = 1'b0;
	logic              wr_index    = 1'b0;
	logic [4:0]        wr_data     = '0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [2:0]        action      = '0;
	logic [23:0]       offset      = '0;
	logic [3:0]        reg_index   = '0;
	logic [31:0]       write_data  = '0;
	logic [2:0]        access_size = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [2:0]        mem_op;
	logic [1:0]        chip_select;
	logic [POS_W-1:0]  mem_pos;
	logic [LEN_W-1:0]  erase_length;
	logic [31:0]       read_data;

	bus_req_t    pending_reqs[$];
	mem_cmd_t    expected_cmds[$];
	int unsigned cycle_count = 0;
	int unsigned reqs_queued = 0;
	logic        failed      = 1'b0;

	// predictor copy of the block state and configuration
	cmd_state_t jedec_state  = CMD_IDLE;
	logic [7:0] control_byte = CONTROL_RST;
	logic [7:0] status_byte  = '0;
	logic [3:0] bank_sw      = SWITCH_RST;
	logic [4:0] pt_units     = '0;

	logic [4:0] phase_banks[6] = '{5'd0, 5'd15, 5'd5, 5'd28, 5'd9, 5'd13};
	logic [4:0] phase_units[6] = '{5'd1, 5'd16, 5'd31, 5'd17, 5'd0, 5'd8};

	banked_flash_command_controller dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.offset       (offset),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.access_size  (access_size),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mem_op       (mem_op),
		.chip_select  (chip_select),
		.mem_pos      (mem_pos),
		.erase_length (erase_length),
		.read_data    (read_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// no idling at all inside the quiet window
	function automatic logic idle_now();
		if (cycle_count >= 1500 && cycle_count < 3500) return 1'b0;
		return $urandom_range(99) < 13;
	endfunction

	function automatic logic [31:0] byte_mask(input logic [2:0] nbytes);
		case (nbytes)
			3'd0, 3'd1: return 32'h0000_00FF;
			3'd2: return 32'h0000_FFFF;
			3'd3: return 32'h00FF_FFFF;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// window offset to chip and position; 0 when nothing is mapped
	function automatic logic map_window(input logic [23:0] off, output logic [1:0] chip,
			output logic [POS_W-1:0] pos);
		int unsigned units, bank, mask, base;
		chip = CHIP_MAIN;
		pos = '0;
		if (control_byte[5]) begin
			units = (pt_units > PT_MAX_UNITS) ? PT_MAX_UNITS : pt_units;
			if (units == 0) return 1'b0;
			chip = CHIP_PASS;
			pos = POS_W'(off % (units * UNIT_BYTES));
			return 1'b1;
		end
		if (control_byte[7]) begin
			chip = CHIP_BACKUP;
			pos = POS_W'((off & 24'h03FFFF) % BACKUP_BYTES);
			return 1'b1;
		end
		bank = status_byte[7] ? status_byte[3:0] : bank_sw;
		if (bank < 8) begin
			mask = 'h3FFFF;
			base = bank * 'h40000;
		end else if (bank < 12) begin
			mask = 'h7FFFF;
			base = (bank - 8) * 'h80000;
		end else if (bank < 14) begin
			mask = 'hFFFFF;
			base = (bank - 12) * 'h100000;
		end else begin
			mask = 'h1FFFFF;
			base = 0;
		end
		pos = POS_W'(((off & mask) + base) % MAIN_BYTES);
		return 1'b1;
	endfunction

	function automatic mem_cmd_t decode_access(input bus_req_t r);
		mem_cmd_t c;
		logic [7:0] cmd_byte;
		logic at_5555, at_2aaa, mapped;
		logic [1:0] chip;
		logic [POS_W-1:0] pos;
		int unsigned slen, sbase, csize;
		c = '0;
		cmd_byte = r.wdata[7:0];
		at_5555 = (r.off[15:0] == ADDR_5555) || (r.off[15:0] == ADDR_0555);
		at_2aaa = (r.off[15:0] == ADDR_2AAA) || (r.off[15:0] == ADDR_02AA);
		case (r.act)
			ACT_FLASH_RD: begin
				if (jedec_state == CMD_AUTOSEL) begin
					c.op = OP_IMM;
					case (r.off[1:0])
						2'd0: c.data = control_byte[7] ? ID_BACKUP_MFR : ID_MAIN_MFR;
						2'd1: c.data = control_byte[7] ? ID_BACKUP_DEV : ID_MAIN_DEV;
						default: c.data = '0;
					endcase
				end else if (map_window(r.off, chip, pos)) begin
					c.op = OP_READ;
					c.chip = chip;
					c.pos = pos;
				end else begin
					c.op = OP_IMM;
					c.data = byte_mask(r.nbytes);
				end
			end
			ACT_FLASH_WR: begin
				if (jedec_state != CMD_PROGRAM && cmd_byte == FC_RESET) begin
					jedec_state = CMD_IDLE;
				end else begin
					case (jedec_state)
						CMD_IDLE: begin
							if (at_5555 && cmd_byte == FC_UNLOCK1) jedec_state = CMD_UNLOCK1;
						end
						CMD_UNLOCK1: begin
							jedec_state = (at_2aaa && cmd_byte == FC_UNLOCK2) ? CMD_UNLOCK2 : CMD_IDLE;
						end
						CMD_UNLOCK2: begin
							if (at_5555 && cmd_byte == FC_ERASE) jedec_state = CMD_ERASE1;
							else if (at_5555 && cmd_byte == FC_AUTOSEL) jedec_state = CMD_AUTOSEL;
							else if (at_5555 && cmd_byte == FC_PROGRAM) jedec_state = CMD_PROGRAM;
							else jedec_state = CMD_IDLE;
						end
						CMD_ERASE1: begin
							jedec_state = (at_5555 && cmd_byte == FC_UNLOCK1) ? CMD_ERASE2 : CMD_IDLE;
						end
						CMD_ERASE2: begin
							jedec_state = (at_2aaa && cmd_byte == FC_UNLOCK2) ? CMD_ERASE3 : CMD_IDLE;
						end
						CMD_ERASE3: begin
							if (at_5555 && cmd_byte == FC_CHIP_ER) begin
								if (!control_byte[5]) begin
									c.op = OP_ECHIP;
									c.chip = control_byte[7] ? CHIP_BACKUP : CHIP_MAIN;
								end
							end else if (cmd_byte == FC_SECT_ER) begin
								mapped = map_window(r.off, chip, pos);
								if (mapped && chip != CHIP_PASS) begin
									// backup flash has a non-uniform top boot block
									csize = control_byte[7] ? BACKUP_BYTES : MAIN_BYTES;
									if (!control_byte[7] || pos <= 'h2FFFF) slen = 65536;
									else if (pos <= 'h37FFF) slen = 32768;
									else if (pos <= 'h3BFFF) slen = 8192;
									else slen = 16384;
									sbase = pos & ~(slen - 1);
									if (sbase + slen > csize) slen = csize - sbase;
									c.op = OP_ESECT;
									c.chip = chip;
									c.pos = POS_W'(sbase);
									c.len = LEN_W'(slen);
								end
							end
							jedec_state = CMD_IDLE;
						end
						CMD_PROGRAM: begin
							mapped = map_window(r.off, chip, pos);
							if (mapped && chip != CHIP_PASS) begin
								c.op = OP_PROG;
								c.chip = chip;
								c.pos = pos;
								c.data = r.wdata & byte_mask(r.nbytes);
							end
							jedec_state = CMD_IDLE;
						end
						default: ; // autoselect holds until a reset command
					endcase
				end
			end
			ACT_IO_RD: begin
				c.op = OP_IMM;
				case (r.reg_no)
					REG_ID: c.data = REG_ID_VAL;
					REG_REV: c.data = REG_REV_VAL;
					REG_CONTROL: c.data = status_byte[7] ? control_byte : {4'h0, bank_sw};
					REG_STATUS: c.data = status_byte;
					default: c.data = '0;
				endcase
			end
			ACT_IO_WR: begin
				if (r.reg_no == REG_CONTROL) control_byte = r.wdata[7:0];
				else if (r.reg_no == REG_STATUS) status_byte = r.wdata[7:0];
			end
			ACT_WARM_RST: jedec_state = CMD_IDLE;
			default: ;
		endcase
		return c;
	endfunction

	// request driver: the head of pending_reqs is what sits on the bus
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_cmds.push_back(decode_access(pending_reqs.pop_front()));
			end
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() != 0 && !idle_now()) begin
					in_valid    <= 1'b1;
					action      <= pending_reqs[0].act;
					offset      <= pending_reqs[0].off;
					reg_index   <= pending_reqs[0].reg_no;
					write_data  <= pending_reqs[0].wdata;
					access_size <= pending_reqs[0].nbytes;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		mem_cmd_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_cmds.size() == 0) begin
					$error("unexpected result, mem_op %0d", mem_op);
					failed = 1'b1;
				end else begin
					want = expected_cmds.pop_front();
					if (mem_op !== want.op) begin
						$error("mem_op expected %0d got %0d", want.op, mem_op);
						failed = 1'b1;
					end
					if (chip_select !== want.chip) begin
						$error("chip_select expected %0d got %0d", want.chip, chip_select);
						failed = 1'b1;
					end
					if (mem_pos !== want.pos) begin
						$error("mem_pos expected 0x%0h got 0x%0h", want.pos, mem_pos);
						failed = 1'b1;
					end
					if (erase_length !== want.len) begin
						$error("erase_length expected 0x%0h got 0x%0h", want.len, erase_length);
						failed = 1'b1;
					end
					if (read_data !== want.data) begin
						$error("read_data expected 0x%0h got 0x%0h", want.data, read_data);
						failed = 1'b1;
					end
				end
			end
			out_stall <= idle_now();
		end
	end

	task automatic push_req(input logic [2:0] act, input logic [23:0] off,
			input logic [3:0] reg_no, input logic [31:0] wdata, input logic [2:0] nbytes);
		pending_reqs.push_back('{act, off, reg_no, wdata, nbytes});
		reqs_queued++;
	endtask

	task automatic flash_write(input logic [15:0] addr, input logic [7:0] data);
		push_req(ACT_FLASH_WR, {8'($urandom), addr}, 4'($urandom), {24'($urandom), data},
			3'($urandom));
	endtask

	function automatic logic [15:0] addr_5555();
		return $urandom_range(1) ? ADDR_5555 : ADDR_0555;
	endfunction

	function automatic logic [15:0] addr_2aaa();
		return $urandom_range(1) ? ADDR_2AAA : ADDR_02AA;
	endfunction

	task automatic unlock();
		flash_write(addr_5555(), FC_UNLOCK1);
		flash_write(addr_2aaa(), FC_UNLOCK2);
	endtask

	task automatic write_config(input logic idx, input logic [4:0] value);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		if (idx == CFG_BANK_SWITCHES) bank_sw = value[3:0];
		else pt_units = value;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// hold off until every request has produced its command
	task automatic settle();
		while (pending_reqs.size() != 0 || expected_cmds.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_traffic(input int unsigned count);
		int unsigned stop_at, pick;
		logic [23:0] off;
		logic [7:0] v;
		stop_at = reqs_queued + count;
		while (reqs_queued < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				unlock();
				flash_write(addr_5555(), FC_PROGRAM);
				push_req(ACT_FLASH_WR, 24'($urandom), 4'($urandom), $urandom, 3'($urandom));
			end else if (pick < 30) begin
				unlock();
				flash_write(addr_5555(), FC_ERASE);
				unlock();
				off = 24'($urandom);
				// land in the backup boot-block area half the time
				if ($urandom_range(1)) off[17:16] = 2'b11;
				push_req(ACT_FLASH_WR, off, 4'($urandom), {24'($urandom), FC_SECT_ER},
					3'($urandom));
			end else if (pick < 35) begin
				unlock();
				flash_write(addr_5555(), FC_ERASE);
				unlock();
				flash_write(addr_5555(), FC_CHIP_ER);
			end else if (pick < 45) begin
				unlock();
				flash_write(addr_5555(), FC_AUTOSEL);
				repeat ($urandom_range(4, 1)) begin
					push_req(ACT_FLASH_RD, 24'($urandom), 4'($urandom), $urandom,
						3'($urandom));
				end
				if ($urandom_range(2) == 0) begin
					v = 8'($urandom);
					if (v == FC_RESET) v = FC_UNLOCK1;
					flash_write(16'($urandom), v);
				end
				if ($urandom_range(1)) flash_write(16'($urandom), FC_RESET);
				else push_req(ACT_WARM_RST, 24'($urandom), 4'($urandom), $urandom, 3'($urandom));
			end else if (pick < 60) begin
				repeat ($urandom_range(3, 1)) begin
					push_req(ACT_FLASH_RD, 24'($urandom), 4'($urandom), $urandom,
						3'($urandom));
				end
			end else if (pick < 70) begin
				v = 8'($urandom);
				if ($urandom_range(1)) begin
					v[5] = ($urandom_range(3) == 0);
					v[7] = ($urandom_range(2) == 0);
					push_req(ACT_IO_WR, 24'($urandom), REG_CONTROL, {24'($urandom), v},
						3'($urandom));
				end else begin
					push_req(ACT_IO_WR, 24'($urandom), REG_STATUS, {24'($urandom), v},
						3'($urandom));
				end
				push_req(ACT_IO_RD, 24'($urandom), $urandom_range(1) ? REG_CONTROL : REG_STATUS,
					$urandom, 3'($urandom));
			end else if (pick < 78) begin
				push_req(ACT_IO_RD, 24'($urandom), 4'($urandom), $urandom, 3'($urandom));
			end else if (pick < 90) begin
				// broken command sequences
				if ($urandom_range(1)) unlock();
				else flash_write(addr_5555(), FC_UNLOCK1);
				flash_write($urandom_range(1) ? addr_5555() : 16'($urandom), 8'($urandom));
			end else begin
				push_req(3'($urandom), 24'($urandom), 4'($urandom), $urandom, 3'($urandom));
			end
		end
	endtask

	initial begin
		while (cycle_count < LIMIT_CYCLES) @(posedge clk);
		$display("banked_flash_command_controller test failed");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_req(ACT_IO_RD, '0, REG_ID, '0, 3'd1);
		push_req(ACT_IO_RD, 24'hFFFFFF, REG_REV, 32'hFFFF_FFFF, 3'd4);
		push_req(ACT_IO_RD, '0, REG_CONTROL, '0, 3'd1);
		push_req(ACT_FLASH_RD, 24'h000000, 4'h0, '0, 3'd1);
		push_req(ACT_FLASH_RD, 24'hFFFFFF, 4'hF, '0, 3'd4);
		// passthrough with no size configured: unmapped reads, odd sizes
		push_req(ACT_IO_WR, '0, REG_CONTROL, 32'h0000_0020, 3'd1);
		push_req(ACT_FLASH_RD, 24'h123456, '0, '0, 3'd0);
		push_req(ACT_FLASH_RD, 24'h654321, '0, '0, 3'd7);
		push_req(ACT_IO_WR, '0, REG_CONTROL, 32'hFFFF_FF80, 3'd4);
		unlock();
		flash_write(addr_5555(), FC_AUTOSEL);
		push_req(ACT_FLASH_RD, 24'h000000, '0, '0, 3'd1);
		push_req(ACT_FLASH_RD, 24'h000001, '0, '0, 3'd1);
		flash_write(16'h0000, FC_RESET);
		unlock();
		flash_write(addr_5555(), FC_PROGRAM);
		push_req(ACT_FLASH_WR, 24'hFFFFFF, '0, 32'hFFFF_FFFF, 3'd3);
		unlock();
		flash_write(addr_5555(), FC_ERASE);
		unlock();
		push_req(ACT_FLASH_WR, 24'h03C123, '0, {24'h0, FC_SECT_ER}, 3'd1);
		push_req(ACT_WARM_RST, '0, '0, '0, 3'd1);
		push_req(ACT_UNUSED, 24'hFFFFFF, 4'hF, 32'hFFFF_FFFF, 3'd7);
		settle();

		for (int p = 0; p < 6; p++) begin
			write_config(CFG_BANK_SWITCHES, phase_banks[p]);
			write_config(CFG_PT_SIZE, phase_units[p]);
			random_traffic(PHASE_REQS);
			settle();
		end

		if (!failed && expected_cmds.size() == 0) begin
			$display("banked_flash_command_controller test passed");
		end else begin
			$display("banked_flash_command_controller test failed");
		end
		$finish;
	end

endmodule

[banked_flash_command_controller.f]
rtl/bfc_pkg.sv
rtl/bfc_rem.sv
rtl/bfc_ctrl.sv
rtl/bfc_datapath.sv
rtl/banked_flash_command_controller.sv
test/testbench.sv
